// File: hw/rtl/mcct_pkg.sv
package mcct_pkg;

   localparam int CHANNELS        = 4;
   localparam int COUNT_WIDTH     = 16;
   localparam int PERIOD_WIDTH    = 16;
   localparam int MASK_WIDTH      = 4;
   localparam int OP_WIDTH        = 3;
   localparam int CHAN_WIDTH      = 2;
   localparam int COUNT_OUT_WIDTH = 16;
   localparam int NUM_PERIODS     = 4;
   localparam int ADDR_WIDTH      = 5;
   localparam int DATA_WIDTH      = 32;
   localparam int REG_IDX_WIDTH   = 3;

   localparam logic [OP_WIDTH-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_START   = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_RESTART = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_STOP    = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_QUERY   = 3'd4;

   localparam logic [REG_IDX_WIDTH-1:0] REG_PERIOD_CH0  = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_PERIOD_CH1  = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_PERIOD_CH2  = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_PERIOD_CH3  = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_REPEAT_MASK = 3'd4;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd1000;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [PERIOD_WIDTH-1:0] period_type;
   typedef logic [CHANNELS-1:0]     chan_mask_type;

   typedef struct packed {
      logic [MASK_WIDTH-1:0]      expired_mask;
      logic [MASK_WIDTH-1:0]      running_mask;
      logic [COUNT_OUT_WIDTH-1:0] count_now;
   } result_type;

endpackage

// File: hw/rtl/mcct_req_if.sv
interface mcct_req_if import mcct_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_WIDTH-1:0]   op;
   logic [CHAN_WIDTH-1:0] channel;

   modport source (output valid, output op, output channel, input ready);
   modport sink (input valid, input op, input channel, output ready);
endinterface

// File: hw/rtl/mcct_rsp_if.sv
interface mcct_rsp_if import mcct_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [MASK_WIDTH-1:0]      expired_mask;
   logic [MASK_WIDTH-1:0]      running_mask;
   logic [COUNT_OUT_WIDTH-1:0] count_now;

   modport source (output valid, output expired_mask, output running_mask,
                   output count_now, input ready);
   modport sink (input valid, input expired_mask, input running_mask,
                 input count_now, output ready);
endinterface

// File: hw/rtl/multi_channel_compare_timeout.sv
// Four-channel output-compare timer.
// Request channel (req_chan): op is tick, start, restart, stop or query,
// channel picks the compare channel for start, restart and stop. A tick
// advances the free-running counter; every running channel whose compare
// matches the new count expires, then stops or reloads by its period.
// Response channel (rsp_chan): one response per request with the expired
// mask (ticks only), the running mask and the counter after the request.
// Periods and the repeat mask sit on the APB port at 4*index and are to be
// written only while the block is idle, which the block does not enforce;
// reads return the register. Responses are registered. Throughput: one
// request per cycle while req_chan.ready is high; all channel updates are
// done in the accept cycle by one compare and one 16-bit add per channel.
// A two-entry output stage (response register plus skid register) lets one
// more request in while a response is stalled; req_chan.ready falls only
// when both entries are full.
// Reset: counter, compares and running bits clear, periods return to 1000,
// repeat mask to zero, output stage empties.
module multi_channel_compare_timeout import mcct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mcct_req_if.sink              req_chan,
   mcct_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready
);

   period_type                period_ff [NUM_PERIODS];
   period_type                period_in [NUM_PERIODS];
   logic [MASK_WIDTH-1:0]     repeat_ff;
   logic [MASK_WIDTH-1:0]     repeat_in;

   count_type                 count_ff;
   count_type                 count_in;
   count_type                 compare_ff [CHANNELS];
   count_type                 compare_in [CHANNELS];
   chan_mask_type             running_ff;
   chan_mask_type             running_in;
   chan_mask_type             expired;
   chan_mask_type             chan_bit;
   logic                      chan_ok;
   logic                      accept;
   logic                      is_tick;
   logic                      csr_write;
   logic [REG_IDX_WIDTH-1:0]  reg_idx;

   result_type                result;
   result_type                main_ff;
   result_type                main_in;
   result_type                skid_ff;
   result_type                skid_in;
   logic                      main_valid_ff;
   logic                      main_valid_in;
   logic                      skid_valid_ff;
   logic                      skid_valid_in;
   logic                      out_fire;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = paddr[ADDR_WIDTH-1:2];

   always_comb begin
      for (int p = 0; p < NUM_PERIODS; p++) begin
         period_in[p] = period_ff[p];
         if (csr_write && reg_idx == REG_IDX_WIDTH'(p)) begin
            period_in[p] = pwdata[PERIOD_WIDTH-1:0];
         end
      end
      repeat_in = repeat_ff;
      if (csr_write && reg_idx == REG_REPEAT_MASK) begin
         repeat_in = pwdata[MASK_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PERIOD_CH0:  prdata = DATA_WIDTH'(period_ff[0]);
         REG_PERIOD_CH1:  prdata = DATA_WIDTH'(period_ff[1]);
         REG_PERIOD_CH2:  prdata = DATA_WIDTH'(period_ff[2]);
         REG_PERIOD_CH3:  prdata = DATA_WIDTH'(period_ff[3]);
         REG_REPEAT_MASK: prdata = DATA_WIDTH'(repeat_ff);
         default:         prdata = '0;
      endcase
   end

   // timer update
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_tick  = req_chan.op == OP_TICK;
   assign chan_ok  = {1'b0, req_chan.channel} < (CHAN_WIDTH+1)'(CHANNELS);
   assign count_in = is_tick ? count_ff + COUNT_WIDTH'(1) : count_ff;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         chan_bit[c] = chan_ok && (req_chan.channel == CHAN_WIDTH'(c));
      end
   end

   // a repeat reload from a match lands exactly one period ahead, so it
   // equals a fresh load from the new count
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         compare_in[c] = compare_ff[c];
         running_in[c] = running_ff[c];
         expired[c]    = 1'b0;
         unique case (req_chan.op)
            OP_TICK: begin
               if (running_ff[c] && compare_ff[c] == count_in) begin
                  expired[c] = 1'b1;
                  if (repeat_ff[c]) begin
                     compare_in[c] = COUNT_WIDTH'(32'(count_in) + 32'(period_ff[c]));
                  end else begin
                     running_in[c] = 1'b0;
                  end
               end
            end
            OP_START: begin
               if (chan_bit[c]) begin
                  compare_in[c] = COUNT_WIDTH'(32'(count_ff) + 32'(period_ff[c]));
                  running_in[c] = 1'b1;
               end
            end
            OP_RESTART: begin
               if (chan_bit[c]) begin
                  compare_in[c] = COUNT_WIDTH'(32'(count_ff) + 32'(period_ff[c]));
               end
            end
            OP_STOP: begin
               if (chan_bit[c]) begin
                  running_in[c] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign result.expired_mask = MASK_WIDTH'(expired);
   assign result.running_mask = MASK_WIDTH'(running_in);
   assign result.count_now    = COUNT_OUT_WIDTH'(32'(count_in));

   // output stage
   assign out_fire       = main_valid_ff && rsp_chan.ready;
   assign req_chan.ready = !skid_valid_ff;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (skid_valid_ff) begin
         if (out_fire) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!main_valid_ff || out_fire) begin
            main_in       = result;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else begin
         if (out_fire) begin
            main_valid_in = 1'b0;
         end
      end
   end

   assign rsp_chan.valid        = main_valid_ff;
   assign rsp_chan.expired_mask = main_ff.expired_mask;
   assign rsp_chan.running_mask = main_ff.running_mask;
   assign rsp_chan.count_now    = main_ff.count_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         running_ff    <= '0;
         repeat_ff     <= '0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            compare_ff[c] <= '0;
         end
         for (int p = 0; p < NUM_PERIODS; p++) begin
            period_ff[p] <= PERIOD_RESET;
         end
      end else begin
         repeat_ff     <= repeat_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int p = 0; p < NUM_PERIODS; p++) begin
            period_ff[p] <= period_in[p];
         end
         if (accept) begin
            count_ff   <= count_in;
            running_ff <= running_in;
            for (int c = 0; c < CHANNELS; c++) begin
               compare_ff[c] <= compare_in[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a response in front");

   a_count_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      !(accept && is_tick) |=> $stable(count_ff))
      else $error("counter moved without a tick");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.op == OP_STOP) |=> (running_ff & $past(chan_bit)) == '0)
      else $error("stopped channel still running");

   a_no_expiry_off_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_tick && !main_valid_ff) |=> main_ff.expired_mask == '0)
      else $error("expiry reported on a non-tick request");

endmodule

// File: test/mcct_checker.sv
module mcct_checker import mcct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mcct_req_if                   req_chan,
   mcct_rsp_if                   rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   input  logic                  pready,
   output int                    error_count,
   output int                    outstanding,
   output int                    request_count,
   output int                    expiry_count
);
   timeunit 1ns;
   timeprecision 1ps;

   count_type     tick_now;
   count_type     compare_at [CHANNELS];
   chan_mask_type running;
   period_type    period [NUM_PERIODS];
   chan_mask_type repeat_on;
   result_type    pending_rsp [$];

   function automatic result_type timer_step(input logic [OP_WIDTH-1:0]   op,
                                             input logic [CHAN_WIDTH-1:0] ch);
      result_type    r;
      chan_mask_type fired;
      count_type     lead;
      fired = '0;
      case (op)
         OP_TICK: begin
            tick_now = tick_now + 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
               if (running[c] && compare_at[c] == tick_now) begin
                  fired[c] = 1'b1;
                  if (repeat_on[c]) begin
                     compare_at[c] = compare_at[c] + period[c];
                     lead = compare_at[c] - tick_now;
                     // reload landed too far ahead: snap and reload from now
                     if (lead > period[c])
                        compare_at[c] = tick_now + period[c];
                  end else begin
                     running[c] = 1'b0;
                  end
               end
            end
         end
         OP_START: begin
            if (ch < CHANNELS) begin
               compare_at[ch] = tick_now + period[ch];
               running[ch] = 1'b1;
            end
         end
         OP_RESTART: begin
            if (ch < CHANNELS)
               compare_at[ch] = tick_now + period[ch];
         end
         OP_STOP: begin
            if (ch < CHANNELS)
               running[ch] = 1'b0;
         end
         default: ;
      endcase
      r.expired_mask = fired;
      r.running_mask = running;
      r.count_now    = tick_now;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         tick_now  = '0;
         running   = '0;
         repeat_on = '0;
         for (int c = 0; c < CHANNELS; c++)
            compare_at[c] = '0;
         for (int c = 0; c < NUM_PERIODS; c++)
            period[c] = PERIOD_RESET;
         pending_rsp.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[ADDR_WIDTH-1:2] == REG_REPEAT_MASK)
               repeat_on = pwdata[CHANNELS-1:0];
            else if (paddr[ADDR_WIDTH-1:2] <= REG_PERIOD_CH3)
               period[paddr[3:2]] = pwdata[PERIOD_WIDTH-1:0];
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (want.expired_mask != 0)
                  expiry_count++;
               if (rsp_chan.expired_mask !== want.expired_mask) begin
                  $error("expired_mask: expected %h, got %h",
                         want.expired_mask, rsp_chan.expired_mask);
                  error_count++;
               end
               if (rsp_chan.running_mask !== want.running_mask) begin
                  $error("running_mask: expected %h, got %h",
                         want.running_mask, rsp_chan.running_mask);
                  error_count++;
               end
               if (rsp_chan.count_now !== want.count_now) begin
                  $error("count_now: expected %h, got %h",
                         want.count_now, rsp_chan.count_now);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            pending_rsp.push_back(timer_step(req_chan.op, req_chan.channel));
            request_count++;
         end
      end
      outstanding = pending_rsp.size();
   end

endmodule

// File: test/multi_channel_compare_timeout_tb.sv
module multi_channel_compare_timeout_tb;
   import mcct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_WIDTH-1:0] OP_UNUSED_5 = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_7 = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [ADDR_WIDTH-1:0] paddr;
   logic [DATA_WIDTH-1:0] pwdata;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   int send_idle;
   int recv_idle;
   int hold_seq;
   int error_count;
   int outstanding;
   int request_count;
   int expiry_count;

   mcct_req_if req_chan ();
   mcct_rsp_if rsp_chan ();

   multi_channel_compare_timeout dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mcct_checker timer_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .request_count (request_count),
      .expiry_count  (expiry_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side: random back-pressure plus a long hold-off each time hold_seq advances
   initial begin
      int hold_left;
      int seen;
      hold_left = 0;
      seen = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seq != seen) begin
            seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("multi_channel_compare_timeout_tb: done, errors");
      $finish;
   end

   task automatic send(input logic [OP_WIDTH-1:0] op, input logic [CHAN_WIDTH-1:0] ch);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.op      = op;
      req_chan.channel = ch;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_WIDTH-1:0] idx,
                            input logic [DATA_WIDTH-1:0]    value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic configure(input period_type p0, input period_type p1,
                            input period_type p2, input period_type p3,
                            input chan_mask_type rep);
      settle();
      csr_write(REG_PERIOD_CH0, DATA_WIDTH'(p0));
      csr_write(REG_PERIOD_CH1, DATA_WIDTH'(p1));
      csr_write(REG_PERIOD_CH2, DATA_WIDTH'(p2));
      csr_write(REG_PERIOD_CH3, DATA_WIDTH'(p3));
      csr_write(REG_REPEAT_MASK, DATA_WIDTH'(rep));
   endtask

   function automatic period_type pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 80)
         return period_type'($urandom_range(1, 12));
      else if (r < 88)
         return '0;
      else if (r < 94)
         return '1;
      else
         return period_type'($urandom_range(65535));
   endfunction

   task automatic random_requests(input int n, input bit with_hold);
      int                    r;
      logic [OP_WIDTH-1:0]   op;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 60)
            op = OP_TICK;
         else if (r < 75)
            op = OP_START;
         else if (r < 83)
            op = OP_RESTART;
         else if (r < 91)
            op = OP_STOP;
         else
            op = OP_QUERY | OP_WIDTH'($urandom_range(3));
         if (with_hold && i == 50)
            hold_seq++;
         send(op, CHAN_WIDTH'($urandom_range(3)));
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.op      = OP_QUERY;
      req_chan.channel = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b1;
      paddr            = '0;
      pwdata           = '0;
      hold_seq         = 0;
      send_idle        = 11;
      recv_idle        = 65;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // reset settings: queries, spare op codes, ticks, start/restart/stop
      send(OP_QUERY, 2'd0);
      send(OP_UNUSED_5, 2'd1);
      send(OP_UNUSED_6, 2'd2);
      send(OP_UNUSED_7, 2'd3);
      send(OP_TICK, 2'd0);
      for (int c = 0; c < CHANNELS; c++)
         send(OP_START, CHAN_WIDTH'(c));
      send(OP_RESTART, 2'd1);
      send(OP_STOP, 2'd2);
      send(OP_STOP, 2'd2);
      send(OP_TICK, 2'd3);
      send(OP_TICK, 2'd3);

      // short periods, zero and full-scale, mixed one-shot/repeat
      configure(16'd1, 16'd2, 16'd0, 16'hFFFF, 4'b1010);
      for (int c = 0; c < CHANNELS; c++)
         send(OP_START, CHAN_WIDTH'(c));
      repeat (4) send(OP_TICK, 2'd0);
      send(OP_RESTART, 2'd3);
      send(OP_STOP, 2'd1);
      send(OP_TICK, 2'd2);
      send(OP_QUERY, 2'd3);

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle = 11; recv_idle = 65; end
            1: begin send_idle = 65; recv_idle = 11; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         for (int k = 0; k < 2; k++) begin
            configure(pick_period(), pick_period(), pick_period(), pick_period(),
                      chan_mask_type'($urandom_range(15)));
            random_requests(320, mode == 0 && k == 0);
         end
      end

      // zero and full-scale periods: compare sums wrap at the counter width
      configure(16'd0, 16'hFFFF, 16'd0, 16'd5, 4'b1110);
      for (int c = 0; c < CHANNELS; c++)
         send(OP_START, CHAN_WIDTH'(c));
      repeat (20) send(OP_TICK, 2'd0);

      settle();
      repeat (10) @(negedge clock);
      $display("%0d requests checked, %0d with an expiry; idle mixes, back-pressure stall,",
               request_count, expiry_count);
      $display("periods from zero to full scale, one-shot and repeat, compare wrap");
      if (outstanding != 0)
         $error("%0d responses never arrived", outstanding);
      if (error_count == 0 && outstanding == 0)
         $display("multi_channel_compare_timeout_tb: done, clean");
      else
         $display("multi_channel_compare_timeout_tb: done, errors");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/mcct_pkg.sv
hw/rtl/mcct_req_if.sv
hw/rtl/mcct_rsp_if.sv
hw/rtl/multi_channel_compare_timeout.sv
test/mcct_checker.sv
test/multi_channel_compare_timeout_tb.sv
